/* hw/rtl/jnps_pkg.sv */
// Shared constants and register codes for the nine-point Jacobi stencil sweep.
package jnps_pkg;

    localparam int COLS_MAX_DEF   = 128;
    localparam int DATA_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF = 32;

    localparam int FRAC_BITS = 30;
    localparam int ROW_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int UPD_LAT   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_CORNER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_VERTICAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_W_HORIZ     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_W_SOURCE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX       = 3'd6;

    localparam int GRID_ROWS_RST = 128;
    localparam int W_CORNER_RST  = 89478115;
    localparam int W_VERT_RST    = 178956230;
    localparam int W_HORIZ_RST   = 178956230;
    localparam int W_SOURCE_RST  = 88762;
    localparam int RELAX_RST     = 1073741824;

endpackage

/* hw/rtl/jnps_update.sv */
// Pipelined weighted-sum, floor shift, relaxation and saturation datapath.
module jnps_update #(
    parameter int DATA_WIDTH = jnps_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = jnps_pkg::COEF_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH+1:0] i_corners,
    input  logic signed [DATA_WIDTH:0]   i_vert,
    input  logic signed [DATA_WIDTH:0]   i_horz,
    input  logic signed [DATA_WIDTH-1:0] i_old,
    input  logic signed [DATA_WIDTH-1:0] i_src,
    input  logic signed [COEF_WIDTH-1:0] i_w_corner,
    input  logic signed [COEF_WIDTH-1:0] i_w_vert,
    input  logic signed [COEF_WIDTH-1:0] i_w_horz,
    input  logic signed [COEF_WIDTH-1:0] i_w_src,
    input  logic        [COEF_WIDTH-2:0] i_relax,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_new_value
);

    localparam int FRAC   = jnps_pkg::FRAC_BITS;
    localparam int LAT    = jnps_pkg::UPD_LAT;
    localparam int PRD_W  = COEF_WIDTH + DATA_WIDTH + 2;
    localparam int OLDQ_W = DATA_WIDTH + FRAC;
    localparam int SUM_W  = ((PRD_W > OLDQ_W) ? PRD_W : OLDQ_W) + 3;
    localparam int CORR_W = SUM_W - FRAC;
    localparam int PROD_W = COEF_WIDTH + CORR_W;
    localparam int TOT_W  = ((PROD_W > OLDQ_W) ? PROD_W : OLDQ_W) + 1;
    localparam int TSH_W  = TOT_W - FRAC;

    logic [LAT-1:0] r_vld;

    logic signed [PRD_W-1:0]      r_pc, r_pv, r_ph, r_ps;
    logic signed [SUM_W-1:0]      r_sa, r_sb;
    logic signed [CORR_W-1:0]     r_corr;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [DATA_WIDTH-1:0] r_old1, r_old2, r_old3, r_old4;
    logic signed [DATA_WIDTH-1:0] r_out;

    logic signed [SUM_W-1:0]      w_oldq2;
    logic signed [SUM_W-1:0]      w_sum;
    logic signed [TOT_W-1:0]      w_oldq5;
    logic signed [TOT_W-1:0]      w_prod5;
    logic signed [TOT_W-1:0]      w_tot;
    logic        [TSH_W-1:0]      w_tsh;
    logic                         w_fits;
    logic signed [DATA_WIDTH-1:0] w_sat;

    always_comb begin
        w_oldq2 = $signed({r_old1, {FRAC{1'b0}}});
        w_sum   = r_sa + r_sb;
        w_oldq5 = $signed({r_old4, {FRAC{1'b0}}});
        w_prod5 = r_prod;
        w_tot   = w_oldq5 + w_prod5;
        w_tsh   = w_tot[TOT_W-1:FRAC];
        w_fits  = (&w_tsh[TSH_W-1:DATA_WIDTH-1]) || !(|w_tsh[TSH_W-1:DATA_WIDTH-1]);
        if (w_fits) begin
            w_sat = $signed(w_tsh[DATA_WIDTH-1:0]);
        end else if (w_tsh[TSH_W-1]) begin
            w_sat = $signed({1'b1, {(DATA_WIDTH-1){1'b0}}});
        end else begin
            w_sat = $signed({1'b0, {(DATA_WIDTH-1){1'b1}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc   <= i_w_corner * i_corners;
            r_pv   <= i_w_vert * i_vert;
            r_ph   <= i_w_horz * i_horz;
            r_ps   <= i_w_src * i_src;
            r_old1 <= i_old;
            r_sa   <= r_pc + r_pv;
            r_sb   <= r_ph + r_ps - w_oldq2;
            r_old2 <= r_old1;
            r_corr <= $signed(w_sum[SUM_W-1:FRAC]);
            r_old3 <= r_old2;
            r_prod <= $signed({1'b0, i_relax}) * r_corr;
            r_old4 <= r_old3;
            r_out  <= w_sat;
        end
    end

    assign o_valid     = r_vld[LAT-1];
    assign o_new_value = r_out;

endmodule

/* hw/rtl/jacobi_nine_point_stencil_sweep_top.sv */
// Top level of the streaming nine-point Jacobi stencil sweep.
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_phi_value, i_source_value
//  result    out        o_valid / i_stall  o_new_value, o_row_index, o_col_index,
//                                          o_last_of_sweep
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One item per cycle unless the result stalls; the single line store is read once and written once per item.
// A result passes the line-store read, window and update registers after its input; boundary points give none.
// Synchronous active-low reset clears control only; line store needs no clearing pass.
// A stalled result freezes the whole pipeline and the input stalls in the same cycle.
module jacobi_nine_point_stencil_sweep_top #(
    parameter int COLS_MAX   = jnps_pkg::COLS_MAX_DEF,
    parameter int DATA_WIDTH = jnps_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = jnps_pkg::COEF_WIDTH_DEF,
    localparam int COL_W     = $clog2(COLS_MAX),
    localparam int CFG_W0    = (COEF_WIDTH > jnps_pkg::ROW_W) ? COEF_WIDTH : jnps_pkg::ROW_W,
    localparam int CFG_W     = (CFG_W0 > COL_W + 1) ? CFG_W0 : COL_W + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [DATA_WIDTH-1:0]  i_phi_value,
    input  logic signed [DATA_WIDTH-1:0]  i_source_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DATA_WIDTH-1:0]  o_new_value,
    output logic [jnps_pkg::ROW_W-1:0]    o_row_index,
    output logic [COL_W-1:0]              o_col_index,
    output logic                          o_last_of_sweep,
    input  logic                          i_cfg_we,
    input  logic [jnps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    localparam int ROW_W   = jnps_pkg::ROW_W;
    localparam int DW      = DATA_WIDTH;
    localparam int LINE_W  = 3 * DW;
    localparam int TAG_LAT = 2 + jnps_pkg::UPD_LAT;

    // configuration
    logic [COL_W:0]               r_grid_cols;
    logic [ROW_W-1:0]             r_grid_rows;
    logic signed [COEF_WIDTH-1:0] r_w_corner, r_w_vert, r_w_horz, r_w_src;
    logic [COEF_WIDTH-2:0]        r_relax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= (COL_W+1)'(COLS_MAX);
            r_grid_rows <= ROW_W'(jnps_pkg::GRID_ROWS_RST);
            r_w_corner  <= COEF_WIDTH'(jnps_pkg::W_CORNER_RST);
            r_w_vert    <= COEF_WIDTH'(jnps_pkg::W_VERT_RST);
            r_w_horz    <= COEF_WIDTH'(jnps_pkg::W_HORIZ_RST);
            r_w_src     <= COEF_WIDTH'(jnps_pkg::W_SOURCE_RST);
            r_relax     <= (COEF_WIDTH-1)'(jnps_pkg::RELAX_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jnps_pkg::REG_GRID_COLS:  r_grid_cols <= i_cfg_data[COL_W:0];
                jnps_pkg::REG_GRID_ROWS:  r_grid_rows <= i_cfg_data[ROW_W-1:0];
                jnps_pkg::REG_W_CORNER:   r_w_corner  <= $signed(i_cfg_data[COEF_WIDTH-1:0]);
                jnps_pkg::REG_W_VERTICAL: r_w_vert    <= $signed(i_cfg_data[COEF_WIDTH-1:0]);
                jnps_pkg::REG_W_HORIZ:    r_w_horz    <= $signed(i_cfg_data[COEF_WIDTH-1:0]);
                jnps_pkg::REG_W_SOURCE:   r_w_src     <= $signed(i_cfg_data[COEF_WIDTH-1:0]);
                jnps_pkg::REG_RELAX:      r_relax     <= i_cfg_data[COEF_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    // geometry and raster counters
    logic [COL_W:0]   w_cols_eff, w_cols_last, w_col_x;
    logic [ROW_W-1:0] w_rows_eff, w_rows_last;
    logic             w_emit, w_last, w_row_end;
    logic             w_adv, w_accept;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;

    logic             upd_valid;

    always_comb begin
        if (r_grid_cols < (COL_W+1)'(3)) begin
            w_cols_eff = (COL_W+1)'(3);
        end else if (r_grid_cols > (COL_W+1)'(COLS_MAX)) begin
            w_cols_eff = (COL_W+1)'(COLS_MAX);
        end else begin
            w_cols_eff = r_grid_cols;
        end
        w_rows_eff  = (r_grid_rows < ROW_W'(3)) ? ROW_W'(3) : r_grid_rows;
        w_cols_last = w_cols_eff - (COL_W+1)'(1);
        w_rows_last = w_rows_eff - ROW_W'(1);
        w_col_x     = {1'b0, r_col};
        w_emit      = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2)) &&
                      (r_row <= w_rows_last) && (w_col_x <= w_cols_last);
        w_last      = (r_row == w_rows_last) && (w_col_x == w_cols_last);
        w_row_end   = (w_col_x >= w_cols_last);
        if (w_row_end) begin
            n_col = '0;
            n_row = (r_row >= w_rows_last) ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            n_row = r_row;
        end
    end

    assign w_adv    = !(upd_valid && i_stall);
    assign w_accept = i_valid && w_adv;
    assign o_stall  = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // line store: {phi two rows above, phi one row above, f one row above}
    logic [LINE_W-1:0] r_line [COLS_MAX];
    logic [LINE_W-1:0] r_rd;

    logic                 r_v1, r_emit1;
    logic [COL_W-1:0]     r_col1;
    logic signed [DW-1:0] r_phi1, r_src1;

    logic signed [DW-1:0] w_rd_two, w_rd_above, w_rd_src;

    assign w_rd_two   = $signed(r_rd[LINE_W-1:2*DW]);
    assign w_rd_above = $signed(r_rd[2*DW-1:DW]);
    assign w_rd_src   = $signed(r_rd[DW-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_line[r_col];
        end
        if (w_adv && r_v1) begin
            r_line[r_col1] <= {r_rd[2*DW-1:DW], r_phi1, r_src1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_emit1 <= 1'b0;
        end else if (w_adv) begin
            r_v1    <= w_accept;
            r_emit1 <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col1 <= r_col;
            r_phi1 <= i_phi_value;
            r_src1 <= i_source_value;
        end
    end

    // 3x3 window: left and center columns of each row are registered; right column is the incoming read
    logic signed [DW-1:0] r_top_c, r_top_r, r_mid_c, r_mid_r, r_bot_c, r_bot_r;
    logic signed [DW-1:0] r_src_dly;

    logic signed [DW+1:0] w_corners;
    logic signed [DW:0]   w_vert, w_horz;

    always_comb begin
        w_corners = r_top_c + w_rd_two + r_bot_c + r_phi1;
        w_vert    = r_top_r + r_bot_r;
        w_horz    = r_mid_c + w_rd_above;
    end

    logic                 r_v2;
    logic signed [DW+1:0] r_corners2;
    logic signed [DW:0]   r_vert2, r_horz2;
    logic signed [DW-1:0] r_old2, r_f2;

    always_ff @(posedge i_clk) begin
        if (w_adv && r_v1) begin
            r_top_c   <= r_top_r;
            r_top_r   <= w_rd_two;
            r_mid_c   <= r_mid_r;
            r_mid_r   <= w_rd_above;
            r_bot_c   <= r_bot_r;
            r_bot_r   <= r_phi1;
            r_src_dly <= w_rd_src;
        end
        if (w_adv) begin
            r_corners2 <= w_corners;
            r_vert2    <= w_vert;
            r_horz2    <= w_horz;
            r_old2     <= r_mid_r;
            r_f2       <= r_src_dly;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1 && r_emit1;
        end
    end

    // point tags ride alongside the datapath
    logic [ROW_W-1:0]   r_trow [TAG_LAT];
    logic [COL_W-1:0]   r_tcol [TAG_LAT];
    logic [TAG_LAT-1:0] r_tlast;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_trow[0] <= r_row - ROW_W'(1);
            r_tcol[0] <= r_col - COL_W'(1);
            r_tlast   <= {r_tlast[TAG_LAT-2:0], w_last};
            for (int k = 1; k < TAG_LAT; k++) begin
                r_trow[k] <= r_trow[k-1];
                r_tcol[k] <= r_tcol[k-1];
            end
        end
    end

    jnps_update #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_valid     (r_v2),
        .i_corners   (r_corners2),
        .i_vert      (r_vert2),
        .i_horz      (r_horz2),
        .i_old       (r_old2),
        .i_src       (r_f2),
        .i_w_corner  (r_w_corner),
        .i_w_vert    (r_w_vert),
        .i_w_horz    (r_w_horz),
        .i_w_src     (r_w_src),
        .i_relax     (r_relax),
        .o_valid     (upd_valid),
        .o_new_value (o_new_value)
    );

    assign o_valid         = upd_valid;
    assign o_row_index     = r_trow[TAG_LAT-1];
    assign o_col_index     = r_tcol[TAG_LAT-1];
    assign o_last_of_sweep = r_tlast[TAG_LAT-1];

    // the read of a new item never hits the entry being written back
    a_rw_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_v1) |-> (r_col != r_col1))
        else $error("line store read and write collide");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_v1) && $stable(r_v2) && $stable(r_col1)))
        else $error("pipeline moved while frozen");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_row_end) |=> (r_col == '0))
        else $error("column counter did not wrap");

    a_accept_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_valid && i_stall) |=> (r_v2 == $past(r_v2)))
        else $error("stage advanced into a stalled result");

endmodule

/* tb/jacobi_nine_point_stencil_sweep_top_test.sv */
// Self-checking testbench for the nine-point Jacobi stencil sweep top level.
module jacobi_nine_point_stencil_sweep_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jnps_pkg::*;

    localparam int DW            = DATA_WIDTH_DEF;
    localparam int CMAX          = COLS_MAX_DEF;
    localparam int CW            = $clog2(CMAX);
    localparam int CFGW          = COEF_WIDTH_DEF;
    localparam int ITEM_GOAL     = 1750;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_SHOWN     = 10;
    localparam longint DATA_HI   = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint DATA_LO   = -DATA_HI - 1;

    typedef struct packed {
        logic signed [DW-1:0] value;
        logic [ROW_W-1:0]     row;
        logic [CW-1:0]        col;
        logic                 last;
    } update_t;

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFGW-1:0]      data;
        logic [DW-1:0]        phi;
        logic [DW-1:0]        src;
        bit                   typed;
        update_t              want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [DW-1:0] phi_in;
    logic signed [DW-1:0] src_in;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [DW-1:0] new_value;
    logic [ROW_W-1:0]     row_index;
    logic [CW-1:0]        col_index;
    logic                 last_of_sweep;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFGW-1:0]      cfg_data;

    // predictor state
    logic signed [DW-1:0] phi_up1 [CMAX];
    logic signed [DW-1:0] phi_up2 [CMAX];
    logic signed [DW-1:0] src_up1 [CMAX];
    logic signed [DW-1:0] win [3][3];
    logic signed [DW-1:0] src_hold;
    logic [ROW_W-1:0]     at_row;
    logic [CW-1:0]        at_col;
    logic [7:0]           geo_cols;
    logic [15:0]          geo_rows;
    logic signed [31:0]   wt_corner;
    logic signed [31:0]   wt_vert;
    logic signed [31:0]   wt_horiz;
    logic signed [31:0]   wt_src;
    logic [30:0]          relax;

    update_t  pending_updates [$];
    dir_row_t dir_tab [$];

    int  tx_idle;
    int  rx_idle;
    bit  rx_quiet;
    int  items_sent;
    int  updates_seen;
    int  bad;
    int  shown;
    int  cycles;
    int  setups;

    jacobi_nine_point_stencil_sweep_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_phi_value     (phi_in),
        .i_source_value  (src_in),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_new_value     (new_value),
        .o_row_index     (row_index),
        .o_col_index     (col_index),
        .o_last_of_sweep (last_of_sweep),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d updates outstanding", cycles,
                     pending_updates.size());
            $display("jacobi_nine_point_stencil_sweep_top regression: fail");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= !rx_quiet && ($urandom_range(0, 99) < rx_idle);
    end

    always @(posedge clk) begin
        update_t got;
        update_t want;
        got = '{new_value, row_index, col_index, last_of_sweep};
        if (rst_n && out_valid && !out_stall) begin
            if (pending_updates.size() == 0) begin
                bad++;
                if (shown < MAX_SHOWN) begin
                    $display("unexpected update: value %h row %0d col %0d last %0d",
                             got.value, got.row, got.col, got.last);
                    shown++;
                end
            end else begin
                want = pending_updates.pop_front();
                updates_seen++;
                if (got.value !== want.value || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last) begin
                    bad++;
                    if (shown < MAX_SHOWN) begin
                        $display("mismatch: want value %h row %0d col %0d last %0d, got value %h row %0d col %0d last %0d",
                                 want.value, want.row, want.col, want.last,
                                 got.value, got.row, got.col, got.last);
                        shown++;
                    end
                end
            end
        end
    end

    function automatic int used_cols();
        int n;
        n = geo_cols;
        if (n < 3) n = 3;
        if (n > CMAX) n = CMAX;
        return n;
    endfunction

    function automatic int used_rows();
        int n;
        n = geo_rows;
        if (n < 3) n = 3;
        return n;
    endfunction

    // One raster step of the sweep: shift window, update line stores, maybe emit.
    task automatic stencil_step(input logic signed [DW-1:0] p, input logic signed [DW-1:0] s,
                                output bit hit, output update_t upd);
        int cols;
        int rows;
        int r;
        int c;
        longint fc;
        longint wc;
        longint wv;
        longint wh;
        longint ws;
        longint rl;
        longint old;
        longint corners;
        longint vert;
        longint horz;
        longint oldq;
        longint sum;
        longint corr;
        longint nv;
        cols = used_cols();
        rows = used_rows();
        r = at_row;
        c = at_col;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = phi_up2[c];
        win[1][2] = phi_up1[c];
        win[2][2] = p;
        phi_up2[c] = phi_up1[c];
        phi_up1[c] = p;
        fc = src_hold;
        src_hold = src_up1[c];
        src_up1[c] = s;
        hit = 1'b0;
        upd = '0;
        if (r >= 2 && c >= 2 && r <= rows - 1 && c <= cols - 1) begin
            wc = wt_corner;
            wv = wt_vert;
            wh = wt_horiz;
            ws = wt_src;
            rl = relax;
            old = win[1][1];
            corners = win[0][0];
            corners = corners + win[0][2] + win[2][0] + win[2][2];
            vert = win[0][1];
            vert = vert + win[2][1];
            horz = win[1][0];
            horz = horz + win[1][2];
            oldq = old <<< FRAC_BITS;
            sum = wc * corners + wv * vert + wh * horz + ws * fc - oldq;
            corr = sum >>> FRAC_BITS;
            nv = (oldq + rl * corr) >>> FRAC_BITS;
            if (nv > DATA_HI) nv = DATA_HI;
            if (nv < DATA_LO) nv = DATA_LO;
            upd.value = DW'(nv);
            upd.row = ROW_W'(r - 1);
            upd.col = CW'(c - 1);
            upd.last = (r == rows - 1) && (c == cols - 1);
            hit = 1'b1;
        end
        if (c >= cols - 1) begin
            at_col = '0;
            at_row = (r >= rows - 1) ? '0 : ROW_W'(r + 1);
        end else begin
            at_col = CW'(c + 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFGW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_GRID_COLS:  geo_cols = data[7:0];
            REG_GRID_ROWS:  geo_rows = data[15:0];
            REG_W_CORNER:   wt_corner = data;
            REG_W_VERTICAL: wt_vert = data;
            REG_W_HORIZ:    wt_horiz = data;
            REG_W_SOURCE:   wt_src = data;
            REG_RELAX:      relax = data[30:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic send_item(input logic [DW-1:0] p, input logic [DW-1:0] s,
                             input bit typed, input update_t want);
        bit hit;
        update_t upd;
        if (cfg_we) cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < tx_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        phi_in <= p;
        src_in <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        stencil_step(p, s, hit, upd);
        if (typed) begin
            upd = want;
            hit = 1'b1;
        end
        if (hit) pending_updates.push_back(upd);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic hold_for_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_updates.size() != 0) @(negedge clk);
    endtask

    // Drain all updates, flush boundary points still in flight, switch idle rates.
    task automatic settle(input int tx_pct, input int rx_pct);
        hold_for_drain();
        @(posedge clk);
        rx_quiet = 1'b1;
        tx_idle = tx_pct;
        rx_idle = rx_pct;
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
        rx_quiet = 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [DW-1:0] rand_data();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(DW-1){1'b1}}};
            1: return {1'b1, {(DW-1){1'b0}}};
            2: return '0;
            3, 4, 5: return DW'($urandom);
            default: return DW'($urandom_range(0, 2 << 20) - (1 << 20));
        endcase
    endfunction

    function automatic logic [CFGW-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4: return $urandom;
            default: return $urandom_range(0, 1 << 29) - (1 << 28);
        endcase
    endfunction

    function automatic logic [CFGW-1:0] rand_relax();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h4000_0000;
            3: return $urandom;
            default: return $urandom_range(32'h2000_0000, 32'h7800_0000);
        endcase
    endfunction

    function automatic logic [CFGW-1:0] rand_cols();
        logic [CFGW-1:0] v;
        case ($urandom_range(0, 19))
            0: v = $urandom_range(0, 2);
            1: v = CMAX;
            2: v = $urandom_range(CMAX + 1, 255);
            3: v = 255;
            default: v = $urandom_range(3, 12);
        endcase
        if ($urandom_range(0, 3) == 0) v[CFGW-1:8] = $urandom;
        return v;
    endfunction

    function automatic logic [CFGW-1:0] rand_rows();
        logic [CFGW-1:0] v;
        v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        if ($urandom_range(0, 3) == 0) v[CFGW-1:16] = $urandom;
        return v;
    endfunction

    task automatic random_setup(input int phase_no);
        int area;
        int n;
        int pause_at;
        if ($urandom_range(0, 1)) write_reg(REG_GRID_COLS, rand_cols());
        if ($urandom_range(0, 1)) write_reg(REG_GRID_ROWS, rand_rows());
        if ($urandom_range(0, 1)) write_reg(REG_W_CORNER, rand_weight());
        if ($urandom_range(0, 1)) write_reg(REG_W_VERTICAL, rand_weight());
        if ($urandom_range(0, 1)) write_reg(REG_W_HORIZ, rand_weight());
        if ($urandom_range(0, 1)) write_reg(REG_W_SOURCE, rand_weight());
        if ($urandom_range(0, 1)) write_reg(REG_RELAX, rand_relax());
        if (used_cols() * used_rows() > 600) write_reg(REG_GRID_ROWS, 3);
        area = used_cols() * used_rows();
        n = (area > 200) ? area : area * $urandom_range(1, 3);
        pause_at = (phase_no == 0 || $urandom_range(0, 2) == 0) ? $urandom_range(1, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) hold_for_drain();
            send_item(rand_data(), rand_data(), 1'b0, '0);
        end
    endtask

    // Geometry shrunk in the middle of a sweep: row cut short, then sweep cut short.
    task automatic midsweep_shrink(input int tx_pct, input int rx_pct);
        write_reg(REG_GRID_COLS, 6);
        write_reg(REG_GRID_ROWS, 16'hFFFF);
        repeat (64) send_item(rand_data(), rand_data(), 1'b0, '0);
        settle(tx_pct, rx_pct);
        write_reg(REG_GRID_COLS, 3);
        repeat (16) send_item(rand_data(), rand_data(), 1'b0, '0);
        settle(tx_pct, rx_pct);
        write_reg(REG_GRID_ROWS, 3);
        while (at_row != 0 || at_col != 0) send_item(rand_data(), rand_data(), 1'b0, '0);
    endtask

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFGW-1:0] data);
        dir_row_t t;
        t = '{default: '0};
        t.is_write = 1'b1;
        t.idx = idx;
        t.data = data;
        return t;
    endfunction

    function automatic dir_row_t item_row(input logic [DW-1:0] p, input logic [DW-1:0] s);
        dir_row_t t;
        t = '{default: '0};
        t.phi = p;
        t.src = s;
        return t;
    endfunction

    // Last point of a 3x3 sweep: the single interior point (1,1).
    function automatic dir_row_t final_row(input logic [DW-1:0] p, input logic [DW-1:0] s,
                                           input logic [DW-1:0] v);
        dir_row_t t;
        t = item_row(p, s);
        t.typed = 1'b1;
        t.want = '{v, ROW_W'(1), CW'(1), 1'b1};
        return t;
    endfunction

    initial begin
        logic [DW-1:0] extreme_vals [9];
        bit writing;
        int phase_no;
        int tx_pct;
        int rx_pct;
        dir_row_t t;

        extreme_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h7FFFFF,
                         24'h000001, 24'h800000, 24'h555555, 24'hAAAAAA};
        rst_n = 1'b0;
        in_valid = 1'b0;
        phi_in = '0;
        src_in = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_idle = 13;
        rx_idle = 55;
        rx_quiet = 1'b0;
        items_sent = 0;
        updates_seen = 0;
        bad = 0;
        shown = 0;
        cycles = 0;
        setups = 0;

        for (int i = 0; i < CMAX; i++) begin
            phi_up1[i] = '0;
            phi_up2[i] = '0;
            src_up1[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) win[k][j] = '0;
        src_hold = '0;
        at_row = '0;
        at_col = '0;
        geo_cols = CMAX;
        geo_rows = GRID_ROWS_RST;
        wt_corner = W_CORNER_RST;
        wt_vert = W_VERT_RST;
        wt_horiz = W_HORIZ_RST;
        wt_src = W_SOURCE_RST;
        relax = RELAX_RST;

        // clamped 3x3 geometry, reset weights
        dir_tab.push_back(cfg_row(REG_GRID_COLS, 0));
        dir_tab.push_back(cfg_row(REG_GRID_ROWS, 2));
        for (int i = 0; i < 9; i++) dir_tab.push_back(item_row(extreme_vals[i], extreme_vals[8-i]));
        // no relaxation: point keeps its old value
        dir_tab.push_back(cfg_row(REG_RELAX, 0));
        for (int i = 0; i < 8; i++) dir_tab.push_back(item_row(extreme_vals[i], ~extreme_vals[i]));
        dir_tab.push_back(final_row(extreme_vals[8], ~extreme_vals[8], 24'h7FFFFF));
        // most negative weights, largest relax: saturates low
        dir_tab.push_back(cfg_row(REG_W_CORNER, 32'h8000_0000));
        dir_tab.push_back(cfg_row(REG_W_VERTICAL, 32'h8000_0000));
        dir_tab.push_back(cfg_row(REG_W_HORIZ, 32'h8000_0000));
        dir_tab.push_back(cfg_row(REG_W_SOURCE, 32'h8000_0000));
        dir_tab.push_back(cfg_row(REG_RELAX, 32'h7FFF_FFFF));
        for (int i = 0; i < 8; i++) dir_tab.push_back(item_row(24'h7FFFFF, 24'h7FFFFF));
        dir_tab.push_back(final_row(24'h7FFFFF, 24'h7FFFFF, 24'h800000));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        writing = 1'b0;
        for (int i = 0; i < dir_tab.size(); i++) begin
            t = dir_tab[i];
            if (t.is_write) begin
                if (!writing) begin
                    settle(13, 55);
                    setups++;
                end
                writing = 1'b1;
                write_reg(t.idx, t.data);
            end else begin
                writing = 1'b0;
                send_item(t.phi, t.src, t.typed, t.want);
            end
        end

        phase_no = 0;
        while (items_sent < ITEM_GOAL) begin
            if (items_sent < ITEM_GOAL / 3) begin
                tx_pct = 13;
                rx_pct = 55;
            end else if (items_sent < 2 * ITEM_GOAL / 3) begin
                tx_pct = 55;
                rx_pct = 13;
            end else begin
                tx_pct = 0;
                rx_pct = 0;
            end
            settle(tx_pct, rx_pct);
            if (phase_no == 3) midsweep_shrink(tx_pct, rx_pct);
            else random_setup(phase_no);
            phase_no++;
            setups++;
        end
        settle(0, 0);

        $display("covered %0d input transfers over %0d register setups, %0d updates checked",
                 items_sent, setups, updates_seen);
        $display("clamped and extreme geometry, saturation both ways, mid-sweep shrink, %0d bad",
                 bad);
        if (bad == 0) begin
            $display("jacobi_nine_point_stencil_sweep_top regression: pass");
        end else begin
            $display("jacobi_nine_point_stencil_sweep_top regression: fail");
        end
        $finish;
    end

endmodule
